FILE: sv/assert_macros.svh
// Assertion macros shared by the sequence window ack tracker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define SWAT_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define SWAT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/swat_pkg.sv
// Types, codes and constants of the sequence window ack tracker.
`default_nettype none
package swat_pkg;

    localparam int STATE_W      = 32;
    localparam int SEQ_W        = 9;
    localparam int SEQ_HI_W     = STATE_W - SEQ_W;
    localparam int SEND_HISTORY = 32;
    localparam int HIST_AW      = $clog2(SEND_HISTORY);
    localparam int CNT_W        = 6;
    localparam int BYTES_W      = 3;
    localparam int IN_DATA_W    = 56;
    localparam int OUT_DATA_W   = 64;

    localparam logic [STATE_W-1:0] FLOOR_GAP       = 32'd32;
    localparam logic [STATE_W-1:0] FULL_MARK       = 32'd30;
    localparam logic [STATE_W-1:0] MAX_OUTSTANDING = 32'd63;
    localparam logic [BYTES_W-1:0] MAX_ACK_BYTES   = 3'd4;
    localparam logic [4:0]         BYTES_SAT_DIFF  = 5'd25;

    typedef enum logic {
        ACT_RECEIVE = 1'b0,
        ACT_BUILD   = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        PT_DATA    = 2'd0,
        PT_PING    = 2'd1,
        PT_ACK     = 2'd2,
        PT_INVALID = 2'd3
    } t_ptype;

    typedef enum logic [1:0] {
        KIND_NOTIFY    = 2'd0,
        KIND_RECV_DONE = 2'd1,
        KIND_BUILT     = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_BAD_CONNECT = 3'd1,
        ST_BAD_HEADER  = 3'd2,
        ST_SEQ_WINDOW  = 3'd3,
        ST_ACK_WINDOW  = 3'd4,
        ST_REFUSED     = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXT,
        S_EVAL,
        S_DECIDE,
        S_NOTIFY,
        S_DRAIN,
        S_GAP,
        S_COMMIT,
        S_FINAL,
        S_BUILD_OUT
    } t_state;

    typedef struct packed {
        t_kind                kind;
        logic                 last;
        logic                 success;
        t_status              status;
        logic                 deliver;
        logic                 ping;
        logic                 became;
        logic                 full;
        logic [SEQ_W-1:0]     hdr_seq;
        logic [SEQ_W-1:0]     hdr_ack_start;
        logic [BYTES_W-1:0]   hdr_ack_bytes;
        logic [STATE_W-1:0]   hdr_ack_mask;
    } t_result;

    function automatic logic [STATE_W-1:0] byte_mask(input logic [BYTES_W-1:0] bytes);
        logic [STATE_W-1:0] m;
        unique case (bytes)
            3'd0:    m = 32'h0000_0000;
            3'd1:    m = 32'h0000_00FF;
            3'd2:    m = 32'h0000_FFFF;
            3'd3:    m = 32'h00FF_FFFF;
            default: m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

endpackage
`default_nettype wire

FILE: sv/swat_hist_ram.sv
// Send history memory: receive sequence recorded at each data send.
`default_nettype none
module swat_hist_ram (
    input  wire logic                          i_clk,
    input  wire logic                          i_we,
    input  wire logic [swat_pkg::HIST_AW-1:0]  i_waddr,
    input  wire logic [swat_pkg::STATE_W-1:0]  i_wdata,
    input  wire logic                          i_re,
    input  wire logic [swat_pkg::HIST_AW-1:0]  i_raddr,
    output logic      [swat_pkg::STATE_W-1:0]  o_rdata
);
    import swat_pkg::*;

    logic [STATE_W-1:0] r_mem [SEND_HISTORY];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

FILE: sv/swat_out_reg.sv
// One-entry output register for the result stream.
`default_nettype none
module swat_out_reg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire swat_pkg::t_result i_data,
    output logic                   o_free,
    input  wire logic              i_tready,
    output logic                   o_tvalid,
    output swat_pkg::t_result      o_data
);
    import swat_pkg::*;

    logic    r_valid;
    t_result r_data;

    assign o_free   = !r_valid || i_tready;
    assign o_tvalid = r_valid;
    assign o_data   = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_data;
        end
    end

endmodule
`default_nettype wire

FILE: sv/sequence_window_ack_tracker.sv
// Top level of the sequence window ack tracker: header build and receive checks.
// A build runs S_EXT, S_EVAL and S_BUILD_OUT; a rejected receive runs S_EXT, S_EVAL,
// S_DECIDE and S_FINAL. An accepted receive gives one notify per cycle in S_NOTIFY while
// the output register is free, then S_DRAIN, S_GAP, S_COMMIT, S_FINAL (no notifies: from S_GAP).
// One item is in work at a time: a new input is taken only in S_IDLE.
// Synchronous active-low reset clears the tracker state, not the item registers or history memory.
`default_nettype none
`include "assert_macros.svh"
module sequence_window_ack_tracker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic                           i_cfg_data,     // connect_sequence_bit
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // rx_connect_bit, rx_sequence, rx_highest_ack, rx_ack_bytes, rx_ack_mask, zero pad
    input  wire logic [swat_pkg::IN_DATA_W-1:0] s_axis_tdata,
    input  wire logic [2:0]                     s_axis_tuser,   // action, packet_type
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // notify_success, status, deliver_payload, request_ack_send, became_established,
    // window_full, hdr_sequence, hdr_ack_start, hdr_ack_bytes, hdr_ack_mask, zero pad
    output logic [swat_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    output logic [1:0]                          m_axis_tuser,   // result_kind
    output logic                                m_axis_tlast
);
    import swat_pkg::*;

    t_state r_state, n_state;

    logic               r_cfg_bit;
    logic [STATE_W-1:0] r_lsr, r_hacked, r_lsent, r_rxmask, r_floor;
    logic               r_established;
    logic               r_rd_ok;

    t_action            r_action;
    t_ptype             r_ptype;
    logic               r_cbit;
    logic [SEQ_W-1:0]   r_rseq, r_rack;
    logic [BYTES_W-1:0] r_nbytes;
    logic [STATE_W-1:0] r_amask;

    logic [STATE_W-1:0] r_seq, r_ack, r_outst, r_diff, r_count;
    logic               r_step_far;
    logic [4:0]         r_step_lo;
    t_status            r_status;
    logic [CNT_W-1:0]   r_cnt, r_i;
    logic               r_became, r_deliver, r_ping, r_gap_far;
    logic [BYTES_W-1:0] r_bytes;

    logic               w_in_accept;
    logic               w_out_free, w_out_load;
    t_result            w_out_data, w_out_q;
    logic               w_issue, w_ok;
    logic [CNT_W-1:0]   w_dist;
    logic               w_count_over, w_rx_pass, w_refused, w_advance;
    logic [CNT_W-1:0]   w_cnt_sat;
    logic [STATE_W-1:0] w_seq_ext, w_ack_ext, w_step, w_gap, w_rdata;
    logic [5:0]         w_bsum;
    logic [BYTES_W-1:0] w_bytes;
    t_status            w_hdr_status;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_accept   = s_axis_tvalid && s_axis_tready;

    assign w_dist       = r_cnt - r_i;
    assign w_ok         = !w_dist[CNT_W-1] && r_amask[w_dist[4:0]];
    assign w_count_over = r_count > r_outst;
    assign w_rx_pass    = (r_status == ST_OK) && !r_step_far && !w_count_over;
    assign w_cnt_sat    = (|r_count[STATE_W-1:CNT_W]) ? CNT_W'(MAX_OUTSTANDING)
                                                      : r_count[CNT_W-1:0];
    assign w_refused    = (r_ptype == PT_DATA) && (r_outst >= MAX_OUTSTANDING);
    assign w_advance    = (r_state == S_EVAL) && (r_action == ACT_BUILD)
                          && (r_ptype == PT_DATA) && !w_refused;

    assign w_seq_ext = (r_rseq < r_lsr[SEQ_W-1:0])
                       ? {r_lsr[STATE_W-1:SEQ_W] + SEQ_HI_W'(1), r_rseq}
                       : {r_lsr[STATE_W-1:SEQ_W], r_rseq};
    assign w_ack_ext = (r_rack < r_hacked[SEQ_W-1:0])
                       ? {r_hacked[STATE_W-1:SEQ_W] + SEQ_HI_W'(1), r_rack}
                       : {r_hacked[STATE_W-1:SEQ_W], r_rack};
    assign w_step = r_seq - r_lsr;
    assign w_gap  = r_seq - r_floor;

    assign w_bsum  = {1'b0, r_diff[4:0]} + 6'd7;
    assign w_bytes = (|r_diff[STATE_W-1:5] || (r_diff[4:0] >= BYTES_SAT_DIFF))
                     ? MAX_ACK_BYTES : w_bsum[5:3];

    always_comb begin
        if (r_cbit != r_cfg_bit) begin
            w_hdr_status = ST_BAD_CONNECT;
        end else if ((r_nbytes > MAX_ACK_BYTES) || (r_ptype == PT_INVALID)) begin
            w_hdr_status = ST_BAD_HEADER;
        end else begin
            w_hdr_status = ST_OK;
        end
    end

    swat_hist_ram u_hist (
        .i_clk   (i_clk),
        .i_we    (w_advance),
        .i_waddr (r_lsent[HIST_AW-1:0] + HIST_AW'(1)),
        .i_wdata (r_lsr),
        .i_re    (w_issue),
        .i_raddr (r_hacked[HIST_AW-1:0] + r_i[HIST_AW-1:0]),
        .o_rdata (w_rdata)
    );

    swat_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_out_load),
        .i_data   (w_out_data),
        .o_free   (w_out_free),
        .i_tready (m_axis_tready),
        .o_tvalid (m_axis_tvalid),
        .o_data   (w_out_q)
    );

    assign m_axis_tuser = w_out_q.kind;
    assign m_axis_tlast = w_out_q.last;
    assign m_axis_tdata = {3'b000, w_out_q.hdr_ack_mask, w_out_q.hdr_ack_bytes,
                           w_out_q.hdr_ack_start, w_out_q.hdr_seq, w_out_q.full,
                           w_out_q.became, w_out_q.ping, w_out_q.deliver,
                           w_out_q.status, w_out_q.success};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        w_out_load = 1'b0;
        w_out_data = '0;
        w_issue    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_accept) begin
                    n_state = S_EXT;
                end
            end
            S_EXT: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                n_state = (r_action == ACT_BUILD) ? S_BUILD_OUT : S_DECIDE;
            end
            S_DECIDE: begin
                if (!w_rx_pass) begin
                    n_state = S_FINAL;
                end else if (w_cnt_sat == '0) begin
                    n_state = S_GAP;
                end else begin
                    n_state = S_NOTIFY;
                end
            end
            S_NOTIFY: begin
                if (w_out_free) begin
                    w_issue            = 1'b1;
                    w_out_load         = 1'b1;
                    w_out_data.kind    = KIND_NOTIFY;
                    w_out_data.success = w_ok;
                    if (r_i == r_cnt) begin
                        n_state = S_DRAIN;
                    end
                end
            end
            S_DRAIN: begin
                n_state = S_GAP;
            end
            S_GAP: begin
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                n_state = S_FINAL;
            end
            S_FINAL: begin
                if (w_out_free) begin
                    w_out_load         = 1'b1;
                    w_out_data.kind    = KIND_RECV_DONE;
                    w_out_data.last    = 1'b1;
                    w_out_data.status  = r_status;
                    w_out_data.deliver = r_deliver;
                    w_out_data.ping    = r_ping;
                    w_out_data.became  = r_became;
                    w_out_data.full    = (r_outst >= FULL_MARK);
                    n_state            = S_IDLE;
                end
            end
            S_BUILD_OUT: begin
                if (w_out_free) begin
                    w_out_load      = 1'b1;
                    w_out_data.kind = KIND_BUILT;
                    w_out_data.last = 1'b1;
                    w_out_data.full = (r_outst >= FULL_MARK);
                    if (r_status == ST_REFUSED) begin
                        w_out_data.status = ST_REFUSED;
                    end else begin
                        w_out_data.hdr_seq       = r_lsent[SEQ_W-1:0];
                        w_out_data.hdr_ack_start = r_lsr[SEQ_W-1:0];
                        w_out_data.hdr_ack_bytes = r_bytes;
                        w_out_data.hdr_ack_mask  = r_rxmask & byte_mask(r_bytes);
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_bit     <= 1'b0;
            r_lsr         <= '0;
            r_hacked      <= '0;
            r_lsent       <= '0;
            r_rxmask      <= '0;
            r_floor       <= '0;
            r_established <= 1'b0;
            r_rd_ok       <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_cfg_bit <= i_cfg_data;
            end
            r_rd_ok <= w_issue && w_ok;
            if (r_rd_ok) begin
                r_floor <= w_rdata;
            end
            if (w_advance) begin
                r_lsent <= r_lsent + STATE_W'(1);
            end
            if ((r_state == S_DECIDE) && w_rx_pass) begin
                r_rxmask <= (r_rxmask << r_step_lo)
                            | {{(STATE_W-1){1'b0}}, (r_ptype == PT_DATA)};
            end
            if (w_issue && w_ok) begin
                r_established <= 1'b1;
            end
            if (r_state == S_COMMIT) begin
                if (r_gap_far) begin
                    r_floor <= r_seq - FLOOR_GAP;
                end
                r_hacked <= r_ack;
                r_lsr    <= r_seq;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (w_in_accept) begin
                    r_action  <= t_action'(s_axis_tuser[0]);
                    r_ptype   <= t_ptype'(s_axis_tuser[2:1]);
                    r_cbit    <= s_axis_tdata[0];
                    r_rseq    <= s_axis_tdata[9:1];
                    r_rack    <= s_axis_tdata[18:10];
                    r_nbytes  <= s_axis_tdata[21:19];
                    r_amask   <= s_axis_tdata[53:22];
                    r_became  <= 1'b0;
                    r_deliver <= 1'b0;
                    r_ping    <= 1'b0;
                end
            end
            S_EXT: begin
                r_seq   <= w_seq_ext;
                r_ack   <= w_ack_ext;
                r_outst <= r_lsent - r_hacked;
                r_diff  <= r_lsr - r_floor;
                r_amask <= r_amask & byte_mask(r_nbytes);
            end
            S_EVAL: begin
                r_step_far <= |w_step[STATE_W-1:5];
                r_step_lo  <= w_step[4:0];
                r_count    <= r_ack - r_hacked;
                r_bytes    <= w_bytes;
                if (r_action == ACT_BUILD) begin
                    r_status <= w_refused ? ST_REFUSED : ST_OK;
                end else begin
                    r_status <= w_hdr_status;
                end
                if (w_advance) begin
                    r_outst <= r_outst + STATE_W'(1);
                end
            end
            S_DECIDE: begin
                if (r_status == ST_OK) begin
                    if (r_step_far) begin
                        r_status <= ST_SEQ_WINDOW;
                    end else if (w_count_over) begin
                        r_status <= ST_ACK_WINDOW;
                    end
                end
                r_cnt     <= w_cnt_sat;
                r_i       <= CNT_W'(1);
                r_ping    <= w_rx_pass && (r_ptype == PT_PING);
                r_deliver <= w_rx_pass && (r_ptype == PT_DATA) && (r_step_lo != '0);
            end
            S_NOTIFY: begin
                if (w_issue) begin
                    r_i <= r_i + CNT_W'(1);
                    if (w_ok && !r_established) begin
                        r_became <= 1'b1;
                    end
                end
            end
            S_GAP: begin
                r_gap_far <= w_gap > FLOOR_GAP;
            end
            S_COMMIT: begin
                r_outst <= r_lsent - r_ack;
            end
            default: begin
            end
        endcase
    end

    `SWAT_ASSERT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n |=> !m_axis_tvalid, "result valid after reset")
    `SWAT_ASSERT(a_one_item, i_clk, i_rst_n, w_in_accept |=> !s_axis_tready, "input taken while busy")
    `SWAT_ASSERT(a_notify_not_last, i_clk, i_rst_n, m_axis_tvalid && (w_out_q.kind == KIND_NOTIFY) |-> !m_axis_tlast, "notify marked last")
    `SWAT_ASSERT(a_refused_empty, i_clk, i_rst_n, m_axis_tvalid && (w_out_q.status == ST_REFUSED) |-> (w_out_q.hdr_seq == '0) && (w_out_q.hdr_ack_mask == '0) && w_out_q.full, "refused header not empty")

endmodule
`default_nettype wire
